/* design/wdbc_pkg.sv */
// Package for the windowed delta bit-packing coder.
// Holds sizes, register index codes and the bit-length and masking helpers.
// Used by wdbc_sub and windowed_delta_bitpack_coder_core.
`default_nettype none

package wdbc_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int SAMPLE_W   = 32;
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int BITS_W     = 6;

  localparam logic [1:0] REG_WIN_LEN    = 2'd0;
  localparam logic [1:0] REG_VALUE_BITS = 2'd1;
  localparam logic [1:0] REG_GAP_SKIP   = 2'd2;
  localparam logic [1:0] REG_GAP_FILL   = 2'd3;

  typedef logic [SAMPLE_W-1:0] word_t;

  function automatic logic [BITS_W-1:0] bit_len(input word_t x);
    logic [BITS_W-1:0] n;
    n = '0;
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (x[i]) begin
        n = BITS_W'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic word_t low_bits(input word_t x, input logic [BITS_W-1:0] bits);
    word_t m;
    if (bits >= BITS_W'(SAMPLE_W)) begin
      m = '1;
    end else begin
      m = ~({SAMPLE_W{1'b1}} << bits);
    end
    return x & m;
  endfunction

endpackage

`default_nettype wire

/* design/wdbc_sub.sv */
// Shared subtractor of the windowed delta bit-packing coder.
// Gives the wrapping difference and a signed or unsigned less-than flag.
// Depends on wdbc_pkg.
`default_nettype none

module wdbc_sub (
  input  wire wdbc_pkg::word_t a_i,
  input  wire wdbc_pkg::word_t b_i,
  input  wire logic            signed_i,
  output wdbc_pkg::word_t      diff_o,
  output logic                 lt_o
);

  wdbc_pkg::word_t           flip;
  logic [wdbc_pkg::SAMPLE_W:0] full;

  assign flip = signed_i ? {1'b1, {(wdbc_pkg::SAMPLE_W-1){1'b0}}} : '0;
  assign full = {1'b0, a_i ^ flip} - {1'b0, b_i ^ flip};
  assign diff_o = full[wdbc_pkg::SAMPLE_W-1:0];
  assign lt_o   = full[wdbc_pkg::SAMPLE_W];

endmodule

`default_nettype wire

/* design/windowed_delta_bitpack_coder_core.sv */
// Top level of the windowed delta bit-packing coder.
// Uses wdbc_pkg and the shared subtractor wdbc_sub.
// Holds the delta memory, the sequencer and the output register.
`default_nettype none

// The block takes one sample item at a time and is not ready while it works on it. An
// item that flushes nothing is accepted and decided on, then goes through the delta
// and the store, or the raw first value; a skipped gap ends after the decision. A flush
// of the deltas makes two passes over the delta memory, for the minimum and for the
// offset width, then gives the sign, magnitude and width chunks, and then reads and
// gives every offset chunk; the offset chunks are left out when all offsets are zero.
// All data arithmetic goes through one shared 32-bit subtractor and the delta memory
// has one registered read port. Result chunks leave through an output register, so a
// waiting chunk stalls the sequencer only when it needs to place the next one.
module windowed_delta_bitpack_coder_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [31:0]                   sample_i,
  input  wire logic                          is_gap_i,
  input  wire logic                          column_end_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [31:0]                        chunk_value_o,
  output logic [5:0]                         chunk_bits_o,
  output logic                               run_last_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i
);

  localparam int CW = wdbc_pkg::CNT_W;
  localparam int AW = wdbc_pkg::ADDR_W;
  localparam int BW = wdbc_pkg::BITS_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECIDE = 4'd1;
  localparam logic [3:0] ST_RAW    = 4'd2;
  localparam logic [3:0] ST_DELTA  = 4'd3;
  localparam logic [3:0] ST_STORE  = 4'd4;
  localparam logic [3:0] ST_FMIN   = 4'd5;
  localparam logic [3:0] ST_FSIGN  = 4'd6;
  localparam logic [3:0] ST_FMAG   = 4'd7;
  localparam logic [3:0] ST_FOR    = 4'd8;
  localparam logic [3:0] ST_FSIG   = 4'd9;
  localparam logic [3:0] ST_FRD    = 4'd10;
  localparam logic [3:0] ST_FOFF   = 4'd11;

  logic [3:0] state_q, state_d;

  logic [4:0]            ws_q;
  logic [BW-1:0]         vb_q;
  logic                  mask_q;
  wdbc_pkg::word_t       nodata_q;

  wdbc_pkg::word_t       v_q, v_d;
  logic                  act_q, act_d;
  logic                  end_q, end_d;

  wdbc_pkg::word_t       prior_q, prior_d;
  logic                  seen_q, seen_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic                  pv_q, pv_d;
  logic                  first_q, first_d;
  logic                  pre_q, pre_d;
  wdbc_pkg::word_t       d_q, d_d;
  wdbc_pkg::word_t       minv_q, minv_d;
  wdbc_pkg::word_t       mag_q, mag_d;
  wdbc_pkg::word_t       or_q, or_d;
  logic [BW-1:0]         sig_q, sig_d;

  wdbc_pkg::word_t       mem_q [wdbc_pkg::WINDOW_MAX];
  wdbc_pkg::word_t       rd_q;
  logic                  mem_we;

  wdbc_pkg::word_t       alu_a, alu_b, alu_diff;
  logic                  alu_sgn, alu_lt;

  logic                  out_valid_q;
  wdbc_pkg::word_t       out_value_q;
  logic [BW-1:0]         out_bits_q;
  logic                  out_last_q;

  logic                  slot, emit_req, emit_fire, emit_last;
  wdbc_pkg::word_t       emit_val;
  logic [BW-1:0]         emit_bits;

  logic [BW-1:0]         evb, cwid, sig_now;
  logic [CW-1:0]         ews, idx_nx;
  logic                  flush_last, neg_min, in_fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  assign evb  = (vb_q == '0) ? BW'(1) : ((vb_q > BW'(32)) ? BW'(32) : vb_q);
  assign ews  = (ws_q == '0) ? CW'(1) :
                ((CW'(ws_q) > CW'(wdbc_pkg::WINDOW_MAX)) ? CW'(wdbc_pkg::WINDOW_MAX)
                                                        : CW'(ws_q));
  assign cwid = wdbc_pkg::bit_len(wdbc_pkg::word_t'(evb));
  assign sig_now    = wdbc_pkg::bit_len(or_q);
  assign flush_last = pre_q ? !end_q : 1'b1;
  assign neg_min    = !(!minv_q[wdbc_pkg::SAMPLE_W-1] && (minv_q != '0));
  assign idx_nx     = idx_q + CW'(1);
  assign slot       = !out_valid_q || out_ready_i;
  assign emit_fire  = emit_req && slot;

  always_comb begin
    alu_a   = rd_q;
    alu_b   = minv_q;
    alu_sgn = 1'b0;
    unique case (state_q)
      ST_DELTA: begin
        alu_a = v_q;
        alu_b = prior_q;
      end
      ST_FMIN: begin
        alu_sgn = 1'b1;
      end
      ST_FSIGN: begin
        alu_a = '0;
      end
      default: begin
      end
    endcase
  end

  wdbc_sub u_sub (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .signed_i (alu_sgn),
    .diff_o   (alu_diff),
    .lt_o     (alu_lt)
  );

  always_comb begin
    emit_req  = 1'b0;
    emit_val  = '0;
    emit_bits = '0;
    emit_last = 1'b0;
    unique case (state_q)
      ST_RAW: begin
        emit_req  = 1'b1;
        emit_val  = wdbc_pkg::low_bits(v_q, evb);
        emit_bits = evb;
        emit_last = !(end_q && (cnt_q != '0));
      end
      ST_FSIGN: begin
        emit_req  = 1'b1;
        emit_val  = wdbc_pkg::word_t'(neg_min);
        emit_bits = BW'(1);
        emit_last = 1'b0;
      end
      ST_FMAG: begin
        emit_req  = 1'b1;
        emit_val  = wdbc_pkg::low_bits(mag_q, evb);
        emit_bits = evb;
        emit_last = 1'b0;
      end
      ST_FSIG: begin
        emit_req  = 1'b1;
        emit_val  = wdbc_pkg::low_bits(wdbc_pkg::word_t'(sig_now), cwid);
        emit_bits = cwid;
        emit_last = (sig_now == '0) && flush_last;
      end
      ST_FOFF: begin
        emit_req  = 1'b1;
        emit_val  = wdbc_pkg::low_bits(alu_diff, sig_q);
        emit_bits = sig_q;
        emit_last = (idx_nx == cnt_q) && flush_last;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    act_d   = act_q;
    end_d   = end_q;
    prior_d = prior_q;
    seen_d  = seen_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    pv_d    = 1'b0;
    first_d = first_q;
    pre_d   = pre_q;
    d_d     = d_q;
    minv_d  = minv_q;
    mag_d   = mag_q;
    or_d    = or_q;
    sig_d   = sig_q;
    mem_we  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          v_d     = is_gap_i ? nodata_q : sample_i;
          act_d   = !(is_gap_i && mask_q);
          end_d   = column_end_i;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (act_q && !seen_q) begin
          state_d = ST_RAW;
        end else if (act_q) begin
          state_d = ST_DELTA;
        end else if (end_q && (cnt_q != '0)) begin
          pre_d   = 1'b0;
          idx_d   = '0;
          first_d = 1'b1;
          state_d = ST_FMIN;
        end else begin
          if (end_q) begin
            seen_d  = 1'b0;
            prior_d = '0;
            cnt_d   = '0;
          end
          state_d = ST_IDLE;
        end
      end
      ST_RAW: begin
        if (emit_fire) begin
          seen_d  = 1'b1;
          prior_d = v_q;
          if (end_q) begin
            seen_d  = 1'b0;
            prior_d = '0;
            cnt_d   = '0;
          end
          state_d = ST_IDLE;
        end
      end
      ST_DELTA: begin
        d_d = alu_diff;
        if (cnt_q >= ews) begin
          pre_d   = 1'b1;
          idx_d   = '0;
          first_d = 1'b1;
          state_d = ST_FMIN;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        mem_we  = 1'b1;
        cnt_d   = cnt_q + CW'(1);
        prior_d = v_q;
        if (end_q) begin
          pre_d   = 1'b0;
          idx_d   = '0;
          first_d = 1'b1;
          state_d = ST_FMIN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FMIN: begin
        if (idx_q < cnt_q) begin
          pv_d  = 1'b1;
          idx_d = idx_nx;
        end
        if (pv_q) begin
          first_d = 1'b0;
          if (first_q || alu_lt) begin
            minv_d = rd_q;
          end
        end
        if ((idx_q == cnt_q) && !pv_q) begin
          state_d = ST_FSIGN;
        end
      end
      ST_FSIGN: begin
        mag_d = neg_min ? alu_diff : minv_q;
        if (emit_fire) begin
          state_d = ST_FMAG;
        end
      end
      ST_FMAG: begin
        if (emit_fire) begin
          idx_d   = '0;
          or_d    = '0;
          state_d = ST_FOR;
        end
      end
      ST_FOR: begin
        if (idx_q < cnt_q) begin
          pv_d  = 1'b1;
          idx_d = idx_nx;
        end
        if (pv_q) begin
          or_d = or_q | alu_diff;
        end
        if ((idx_q == cnt_q) && !pv_q) begin
          state_d = ST_FSIG;
        end
      end
      ST_FSIG: begin
        if (emit_fire) begin
          sig_d = sig_now;
          idx_d = '0;
          if (sig_now != '0) begin
            state_d = ST_FRD;
          end else begin
            cnt_d = '0;
            if (pre_q) begin
              state_d = ST_STORE;
            end else begin
              seen_d  = 1'b0;
              prior_d = '0;
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_FRD: begin
        state_d = ST_FOFF;
      end
      ST_FOFF: begin
        if (emit_fire) begin
          idx_d = idx_nx;
          if (idx_nx == cnt_q) begin
            cnt_d = '0;
            if (pre_q) begin
              state_d = ST_STORE;
            end else begin
              seen_d  = 1'b0;
              prior_d = '0;
              state_d = ST_IDLE;
            end
          end else begin
            state_d = ST_FRD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cnt_q[AW-1:0]] <= d_q;
    end
    rd_q <= mem_q[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q     <= 5'd16;
      vb_q     <= BW'(32);
      mask_q   <= 1'b0;
      nodata_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wdbc_pkg::REG_WIN_LEN:    ws_q     <= cfg_data_i[4:0];
        wdbc_pkg::REG_VALUE_BITS: vb_q     <= cfg_data_i[BW-1:0];
        wdbc_pkg::REG_GAP_SKIP:   mask_q   <= cfg_data_i[0];
        wdbc_pkg::REG_GAP_FILL:   nodata_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prior_q     <= '0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      pv_q        <= 1'b0;
      first_q     <= 1'b0;
      pre_q       <= 1'b0;
      act_q       <= 1'b0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prior_q <= prior_d;
      seen_q  <= seen_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pv_q    <= pv_d;
      first_q <= first_d;
      pre_q   <= pre_d;
      act_q   <= act_d;
      end_q   <= end_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    d_q    <= d_d;
    minv_q <= minv_d;
    mag_q  <= mag_d;
    or_q   <= or_d;
    sig_q  <= sig_d;
    if (emit_fire) begin
      out_value_q <= emit_val;
      out_bits_q  <= emit_bits;
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chunk_value_o = out_value_q;
  assign chunk_bits_o  = out_bits_q;
  assign run_last_o    = out_last_q;

endmodule

`default_nettype wire

/* tb/sv/tb_windowed_delta_bitpack_coder_core.sv */
// Self-checking testbench for windowed_delta_bitpack_coder_core.
// A chunk predictor class mirrors the coder and checks every output chunk in order.
// Depends on wdbc_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_windowed_delta_bitpack_coder_core;

  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 110;

  class chunk_predictor;
    typedef struct packed {
      logic [31:0] value;
      logic [5:0]  nbits;
      logic        run_last;
    } chunk_t;

    chunk_t      want_q[$];
    logic [4:0]  win_len;
    logic [5:0]  value_bits;
    logic        skip_gaps;
    logic [31:0] gap_fill;
    logic [31:0] deltas[wdbc_pkg::WINDOW_MAX];
    int unsigned n_deltas;
    logic [31:0] prev;
    bit          have_first;
    int          errors;

    function new();
      win_len    = 5'd16;
      value_bits = 6'd32;
      skip_gaps  = 1'b0;
      gap_fill   = '0;
      n_deltas   = 0;
      prev       = '0;
      have_first = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        wdbc_pkg::REG_WIN_LEN: begin
          win_len = data[4:0];
        end
        wdbc_pkg::REG_VALUE_BITS: begin
          value_bits = data[5:0];
        end
        wdbc_pkg::REG_GAP_SKIP: begin
          skip_gaps = data[0];
        end
        wdbc_pkg::REG_GAP_FILL: begin
          gap_fill = data;
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned width_of(logic [31:0] x);
      int unsigned n;
      n = 0;
      for (int i = 31; i >= 0; i--) begin
        if (x[i] && n == 0) begin
          n = i + 1;
        end
      end
      return n;
    endfunction

    function int unsigned value_width();
      if (value_bits == 0) begin
        return 1;
      end
      if (value_bits > 32) begin
        return 32;
      end
      return value_bits;
    endfunction

    function int unsigned window_limit();
      if (win_len == 0) begin
        return 1;
      end
      if (win_len > wdbc_pkg::WINDOW_MAX) begin
        return wdbc_pkg::WINDOW_MAX;
      end
      return win_len;
    endfunction

    function void add_chunk(logic [31:0] v, int unsigned n);
      chunk_t c;
      c.value    = (n >= 32) ? v : (v & ((32'd1 << n) - 32'd1));
      c.nbits    = 6'(n);
      c.run_last = 1'b0;
      want_q.insert(want_q.size(), c);
    endfunction

    function void pack_window();
      logic [31:0] minv;
      logic [31:0] maxoff;
      int unsigned vb;
      int unsigned sig;
      int unsigned cw;
      if (n_deltas == 0) begin
        return;
      end
      vb   = value_width();
      minv = deltas[0];
      for (int i = 1; i < n_deltas; i++) begin
        if ($signed(deltas[i]) < $signed(minv)) begin
          minv = deltas[i];
        end
      end
      if (!minv[31] && minv != 0) begin
        add_chunk(32'd0, 1);
        add_chunk(minv, vb);
      end else begin
        add_chunk(32'd1, 1);
        add_chunk(32'd0 - minv, vb);
      end
      maxoff = '0;
      for (int i = 0; i < n_deltas; i++) begin
        if (deltas[i] - minv > maxoff) begin
          maxoff = deltas[i] - minv;
        end
      end
      sig = width_of(maxoff);
      cw  = width_of(32'(vb));
      add_chunk(32'(sig), cw);
      if (sig > 0) begin
        for (int i = 0; i < n_deltas; i++) begin
          add_chunk(deltas[i] - minv, sig);
        end
      end
      n_deltas = 0;
    endfunction

    function void take_sample(logic [31:0] s, logic g, logic e);
      int unsigned first;
      logic [31:0] v;
      chunk_t      tail;
      first = want_q.size();
      if (!(g && skip_gaps)) begin
        v = g ? gap_fill : s;
        if (!have_first) begin
          have_first = 1;
          add_chunk(v, value_width());
        end else begin
          if (n_deltas >= window_limit()) begin
            pack_window();
          end
          deltas[n_deltas % wdbc_pkg::WINDOW_MAX] = v - prev;
          n_deltas++;
        end
        prev = v;
      end
      if (e) begin
        pack_window();
        n_deltas   = 0;
        have_first = 0;
        prev       = '0;
      end
      if (want_q.size() > first) begin
        tail = want_q[want_q.size() - 1];
        tail.run_last = 1'b1;
        want_q[want_q.size() - 1] = tail;
      end
    endfunction

    function void check_chunk(logic [31:0] v, logic [5:0] n, logic l);
      chunk_t w;
      if (want_q.size() == 0) begin
        $error("unexpected chunk: value %h, bits %0d, run_last %b", v, n, l);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (v !== w.value) begin
        $error("chunk_value: expected %h, got %h", w.value, v);
        errors++;
      end
      if (n !== w.nbits) begin
        $error("chunk_bits: expected %0d, got %0d", w.nbits, n);
        errors++;
      end
      if (l !== w.run_last) begin
        $error("run_last: expected %b, got %b", w.run_last, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [31:0] sample_i     = '0;
  logic        is_gap_i     = 1'b0;
  logic        column_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [31:0] chunk_value_o;
  logic [5:0]  chunk_bits_o;
  logic        run_last_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i  = wdbc_pkg::REG_WIN_LEN;
  logic [31:0] cfg_data_i   = '0;

  chunk_predictor sb;
  bit             quiet = 0;
  int             n_counted = 0;

  windowed_delta_bitpack_coder_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .is_gap_i     (is_gap_i),
    .column_end_i (column_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .chunk_value_o(chunk_value_o),
    .chunk_bits_o (chunk_bits_o),
    .run_last_o   (run_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_chunk(chunk_value_o, chunk_bits_o, run_last_o);
      end
      out_ready_i <= quiet || ($urandom_range(99) >= 22);
    end
  end

  task automatic send_sample(logic [31:0] s, logic g, logic e);
    if (!quiet) begin
      while ($urandom_range(99) < 22) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    sample_i     <= s;
    is_gap_i     <= g;
    column_end_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    n_counted++;
    sb.take_sample(s, g, e);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.want_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  task automatic write_cfg(logic [4:0] ws, logic [5:0] vb, logic mm, logic [31:0] nd);
    write_reg(wdbc_pkg::REG_WIN_LEN, 32'(ws));
    write_reg(wdbc_pkg::REG_VALUE_BITS, 32'(vb));
    write_reg(wdbc_pkg::REG_GAP_SKIP, 32'(mm));
    write_reg(wdbc_pkg::REG_GAP_FILL, nd);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic pick_cfg();
    logic [4:0]  ws;
    logic [5:0]  vb;
    logic [31:0] nd;
    case ($urandom_range(9))
      0: ws = 5'd0;
      1: ws = 5'($urandom_range(17, 31));
      2: ws = 5'd16;
      default: ws = 5'($urandom_range(1, 16));
    endcase
    case ($urandom_range(9))
      0: vb = 6'd0;
      1: vb = 6'($urandom_range(33, 63));
      2, 3, 4: vb = 6'($urandom_range(1, 8));
      default: vb = 6'($urandom_range(9, 32));
    endcase
    nd = ($urandom_range(3) == 0) ? 32'h8000_0000 : $urandom();
    write_cfg(ws, vb, 1'($urandom_range(1)), nd);
  endtask

  function automatic logic [31:0] next_value(logic [31:0] prev_v, int unsigned span_log);
    logic [31:0] span;
    span = 32'd1 << span_log;
    case ($urandom_range(15))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return prev_v;
      default: return prev_v + $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  initial begin
    int unsigned len;
    int unsigned span_log;
    logic [31:0] prev_s;
    logic [31:0] s;
    logic        g;
    logic        e;

    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: wrapping deltas, gap replaced by zero, most negative minimum.
    send_sample(32'h7fff_ffff, 1'b0, 1'b0);
    send_sample(32'h8000_0000, 1'b0, 1'b0);
    send_sample(32'h0000_0000, 1'b1, 1'b0);
    send_sample(32'hffff_ffff, 1'b0, 1'b1);
    wait_idle();

    // Out-of-range zero sizes, mask mode, and a skipped gap that ends the column.
    write_cfg(5'd0, 6'd0, 1'b1, 32'hffff_ffff);
    send_sample(32'd5, 1'b0, 1'b0);
    send_sample(32'd7, 1'b0, 1'b0);
    send_sample(32'd3, 1'b0, 1'b0);
    send_sample(32'h0000_1234, 1'b1, 1'b0);
    send_sample(32'hdead_beef, 1'b1, 1'b1);
    wait_idle();

    // Oversized window, a count field too narrow for the offset width.
    write_cfg(5'd31, 6'd2, 1'b0, 32'h8000_0000);
    send_sample(32'd100, 1'b0, 1'b0);
    send_sample(32'd100, 1'b0, 1'b0);
    send_sample(32'd105, 1'b0, 1'b0);
    send_sample(32'h5555_aaaa, 1'b1, 1'b1);
    wait_idle();

    // The window size is lowered while the window holds five deltas.
    write_cfg(5'd8, 6'd63, 1'b0, 32'h7fff_ffff);
    for (int i = 1; i <= 6; i++) begin
      send_sample(32'(i), 1'b0, 1'b0);
    end
    wait_idle();
    write_cfg(5'd2, 6'd63, 1'b0, 32'h7fff_ffff);
    send_sample(32'd10, 1'b0, 1'b0);
    send_sample(32'd0, 1'b0, 1'b1);
    send_sample(32'd42, 1'b0, 1'b1);
    wait_idle();

    while (n_counted < RANDOM_ITEMS) begin
      pick_cfg();
      repeat ($urandom_range(1, 3)) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 18);
        span_log = $urandom_range(0, 30);
        prev_s = $urandom();
        for (int k = 0; k < len && n_counted < RANDOM_ITEMS; k++) begin
          s = next_value(prev_s, span_log);
          g = ($urandom_range(99) < 12);
          e = (k == len - 1) && ($urandom_range(7) != 0);
          if ($urandom_range(99) < 4) begin
            wait_idle();
          end
          quiet = (n_counted >= 45) && (n_counted < 75);
          send_sample(s, g, e);
          prev_s = s;
        end
      end
      wait_idle();
    end
    quiet = 0;

    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
